[hw/rtl/ppp_pkg.sv]
// Shared types and constants for the perspective point projector.
// No dependencies; every other file imports this package.
package ppp_pkg;

  localparam int IoWidth  = 32;
  localparam int CfgWidth = 64;
  localparam int IdxWidth = 3;

  typedef enum logic [IdxWidth-1:0] {
    REG_X_XY  = 3'd0,
    REG_X_ZO  = 3'd1,
    REG_Y_XY  = 3'd2,
    REG_Y_ZO  = 3'd3,
    REG_W_XY  = 3'd4,
    REG_W_ZO  = 3'd5,
    REG_DEPTH = 3'd6
  } reg_index_t;

  localparam logic [CfgWidth-1:0] ResetXXy = 64'h0001_0000_0000_0000;
  localparam logic [CfgWidth-1:0] ResetYXy = 64'h0000_0000_0001_0000;
  localparam logic [CfgWidth-1:0] ResetWZo = 64'h0000_0000_0001_0000;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  // Flags that travel alongside the division chain.
  typedef struct packed {
    logic dzero;
    logic den_neg;
    logic u_nneg;
    logic u_nzero;
    logic v_nneg;
    logic v_nzero;
    logic u_ovf;
    logic v_ovf;
  } ppp_side_t;

endpackage

[hw/rtl/perspective_point_projector.sv]
// Throughput: one point per cycle; the divider is a chain of VALUE_WIDTH cells,
// one quotient bit each, and every stage stalls only when the stage after it is full.
// Reset clears all valid flags and loads the default projection registers.
// Depends on ppp_pkg and ppp_div_cell.
module perspective_point_projector
  import ppp_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [IdxWidth-1:0]        cfg_index,
  input  logic [CfgWidth-1:0]        cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [IoWidth-1:0]  point_x,
  input  logic signed [IoWidth-1:0]  point_y,
  input  logic signed [IoWidth-1:0]  point_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [IoWidth-1:0]  image_u,
  output logic signed [IoWidth-1:0]  image_v,
  output logic [1:0]                 status
);

  localparam int VW = VALUE_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int SW = 2 * VW + 3;
  localparam int MW = SW;
  localparam int CW = MW + FB + VW;

  // Configuration registers.
  logic [CfgWidth-1:0] rows [6];
  logic [IoWidth-1:0]  depth_eps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0]   <= ResetXXy;
      rows[1]   <= '0;
      rows[2]   <= ResetYXy;
      rows[3]   <= '0;
      rows[4]   <= '0;
      rows[5]   <= ResetWZo;
      depth_eps <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_XY:  rows[0] <= cfg_data;
        REG_X_ZO:  rows[1] <= cfg_data;
        REG_Y_XY:  rows[2] <= cfg_data;
        REG_Y_ZO:  rows[3] <= cfg_data;
        REG_W_XY:  rows[4] <= cfg_data;
        REG_W_ZO:  rows[5] <= cfg_data;
        REG_DEPTH: depth_eps <= cfg_data[IoWidth-1:0];
        default: ;
      endcase
    end
  end

  logic signed [VW-1:0] wx [3], wy [3], wz [3], wo [3], eps;
  logic signed [VW-1:0] px, py, pz;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      wx[r] = rows[2*r][32 +: VW];
      wy[r] = rows[2*r][0 +: VW];
      wz[r] = rows[2*r+1][32 +: VW];
      wo[r] = rows[2*r+1][0 +: VW];
    end
  end

  assign eps = depth_eps[VW-1:0];
  assign px  = point_x[VW-1:0];
  assign py  = point_y[VW-1:0];
  assign pz  = point_z[VW-1:0];

  // Stage 1: products.
  logic                   v1, r1;
  logic signed [2*VW-1:0] prod [3][3];
  logic signed [SW-1:0]   offs [3];

  // Stage 2: row sums.
  logic                 v2, r2;
  logic signed [SW-1:0] sum [3];

  // Stage 3: magnitudes and sign flags.
  logic          v3, r3;
  logic [MW-1:0] mag_u, mag_v, mag_d;
  ppp_side_t     side3;

  // Stage 4: overflow check and initial remainders.
  logic          v4, r4;
  logic [MW-1:0] ru4, rv4, d4;
  logic [VW-1:0] lu4, lv4;
  ppp_side_t     side4;

  logic r_chain_out, v_chain_out;

  assign r1       = !v1 || r2;
  assign r2       = !v2 || r3;
  assign r3       = !v3 || r4;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= px * wx[r];
        prod[r][1] <= py * wy[r];
        prod[r][2] <= pz * wz[r];
        offs[r]    <= (r == 2) ? (SW'(wo[r]) + SW'(eps)) <<< FB : SW'(wo[r]) <<< FB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      for (int r = 0; r < 3; r++) begin
        sum[r] <= SW'(prod[r][0]) + SW'(prod[r][1]) + SW'(prod[r][2]) + offs[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      mag_u         <= sum[0][SW-1] ? MW'(-sum[0]) : MW'(sum[0]);
      mag_v         <= sum[1][SW-1] ? MW'(-sum[1]) : MW'(sum[1]);
      mag_d         <= sum[2][SW-1] ? MW'(-sum[2]) : MW'(sum[2]);
      side3.dzero   <= sum[2] == '0;
      side3.den_neg <= sum[2][SW-1];
      side3.u_nneg  <= sum[0][SW-1];
      side3.u_nzero <= sum[0] == '0;
      side3.v_nneg  <= sum[1][SW-1];
      side3.v_nzero <= sum[1] == '0;
      side3.u_ovf   <= 1'b0;
      side3.v_ovf   <= 1'b0;
    end
  end

  logic [CW-1:0] nu, nv, dd;

  assign nu = CW'(mag_u) << FB;
  assign nv = CW'(mag_v) << FB;
  assign dd = CW'(mag_d) << VW;

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      // The quotient fits VW bits exactly when the scaled numerator is below den * 2^VW.
      side4 <= '{dzero:   side3.dzero,
                 den_neg: side3.den_neg,
                 u_nneg:  side3.u_nneg,
                 u_nzero: side3.u_nzero,
                 v_nneg:  side3.v_nneg,
                 v_nzero: side3.v_nzero,
                 u_ovf:   nu >= dd,
                 v_ovf:   nv >= dd};
      ru4   <= nu[VW +: MW];
      rv4   <= nv[VW +: MW];
      lu4   <= nu[VW-1:0];
      lv4   <= nv[VW-1:0];
      d4    <= mag_d;
    end
  end

  // Division chain.
  logic          cv   [VW+1];
  logic          cr   [VW+1];
  logic [MW-1:0] cden [VW+1];
  logic [MW-1:0] cru  [VW+1];
  logic [MW-1:0] crv  [VW+1];
  logic [VW-1:0] clu  [VW+1];
  logic [VW-1:0] clv  [VW+1];
  logic [VW-1:0] cqu  [VW+1];
  logic [VW-1:0] cqv  [VW+1];
  ppp_side_t     cside [VW+1];

  assign cv[0]    = v4;
  assign r4       = cr[0];
  assign cden[0]  = d4;
  assign cru[0]   = ru4;
  assign crv[0]   = rv4;
  assign clu[0]   = lu4;
  assign clv[0]   = lv4;
  assign cqu[0]   = '0;
  assign cqv[0]   = '0;
  assign cside[0] = side4;

  for (genvar k = 0; k < VW; k++) begin : g_cell
    ppp_div_cell #(.MW(MW), .VW(VW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[k]),
      .in_ready (cr[k]),
      .den_in   (cden[k]),
      .ru_in    (cru[k]),
      .rv_in    (crv[k]),
      .lu_in    (clu[k]),
      .lv_in    (clv[k]),
      .qu_in    (cqu[k]),
      .qv_in    (cqv[k]),
      .side_in  (cside[k]),
      .out_valid(cv[k+1]),
      .out_ready(cr[k+1]),
      .den_out  (cden[k+1]),
      .ru_out   (cru[k+1]),
      .rv_out   (crv[k+1]),
      .lu_out   (clu[k+1]),
      .lv_out   (clv[k+1]),
      .qu_out   (cqu[k+1]),
      .qv_out   (cqv[k+1]),
      .side_out (cside[k+1])
    );
  end

  assign v_chain_out = cv[VW];
  assign r_chain_out = !out_valid || out_ready;
  assign cr[VW]      = r_chain_out;

  // Final stage: sign, saturation and zero-depth handling.
  localparam logic [VW-1:0] MaxVal = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] MinVal = {1'b1, {(VW-1){1'b0}}};

  ppp_side_t     fs;
  logic [VW-1:0] qu, qv, res_u, res_v;
  logic          neg_u, neg_v, sat_u, sat_v;

  assign fs    = cside[VW];
  assign qu    = cqu[VW];
  assign qv    = cqv[VW];
  assign neg_u = fs.u_nneg ^ fs.den_neg;
  assign neg_v = fs.v_nneg ^ fs.den_neg;
  assign sat_u = fs.u_ovf || (neg_u ? (qu > MinVal) : qu[VW-1]);
  assign sat_v = fs.v_ovf || (neg_v ? (qv > MinVal) : qv[VW-1]);

  always_comb begin
    if (fs.dzero) begin
      res_u = fs.u_nzero ? '0 : (fs.u_nneg ? MinVal : MaxVal);
      res_v = fs.v_nzero ? '0 : (fs.v_nneg ? MinVal : MaxVal);
    end else begin
      res_u = sat_u ? (neg_u ? MinVal : MaxVal) : (neg_u ? VW'(-qu) : qu);
      res_v = sat_v ? (neg_v ? MinVal : MaxVal) : (neg_v ? VW'(-qv) : qv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r_chain_out) begin
      out_valid <= v_chain_out;
    end
  end

  always_ff @(posedge clk) begin
    if (r_chain_out && v_chain_out) begin
      image_u <= IoWidth'(signed'(res_u));
      image_v <= IoWidth'(signed'(res_v));
      if (fs.dzero) begin
        status <= STATUS_ZERO;
      end else if (sat_u || sat_v) begin
        status <= STATUS_SAT;
      end else begin
        status <= STATUS_OK;
      end
    end
  end

endmodule

[hw/rtl/ppp_div_cell.sv]
// One restoring-division cell: produces one quotient bit for both lanes.
// Depends on ppp_pkg for the sideband flag struct.
module ppp_div_cell
  import ppp_pkg::*;
#(
  parameter int MW = 67,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [MW-1:0] den_in,
  input  logic [MW-1:0] ru_in,
  input  logic [MW-1:0] rv_in,
  input  logic [VW-1:0] lu_in,
  input  logic [VW-1:0] lv_in,
  input  logic [VW-1:0] qu_in,
  input  logic [VW-1:0] qv_in,
  input  ppp_side_t     side_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [MW-1:0] den_out,
  output logic [MW-1:0] ru_out,
  output logic [MW-1:0] rv_out,
  output logic [VW-1:0] lu_out,
  output logic [VW-1:0] lv_out,
  output logic [VW-1:0] qu_out,
  output logic [VW-1:0] qv_out,
  output ppp_side_t     side_out
);

  logic [MW:0] tu, tv;
  logic        bu, bv;

  assign in_ready = !out_valid || out_ready;
  assign tu = {ru_in, lu_in[VW-1]};
  assign tv = {rv_in, lv_in[VW-1]};
  assign bu = tu >= {1'b0, den_in};
  assign bv = tv >= {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      den_out  <= den_in;
      ru_out   <= bu ? MW'(tu - {1'b0, den_in}) : tu[MW-1:0];
      rv_out   <= bv ? MW'(tv - {1'b0, den_in}) : tv[MW-1:0];
      lu_out   <= {lu_in[VW-2:0], 1'b0};
      lv_out   <= {lv_in[VW-2:0], 1'b0};
      qu_out   <= {qu_in[VW-2:0], bu};
      qv_out   <= {qv_in[VW-2:0], bv};
      side_out <= side_in;
    end
  end

endmodule
